### rtl/vdt_pkg.sv
// Package for the vertex deduplication table.
// Holds default sizes, fixed field widths and the token control struct.
// Used by vdt_cell, vertex_dedup_table and vdt_checker.
package vdt_pkg;

    // Default configuration of the table.
    localparam int DEFAULT_TABLE_DEPTH = 256;
    localparam int DEFAULT_COORD_BITS  = 16;

    // Fixed widths of the external fields.
    localparam int COORD_W = 16;
    localparam int INDEX_W = 8;

    // Control part of the search token that walks along the cell chain.
    typedef struct packed {
        logic valid;
        logic found;
        logic is_new;
        logic face_end;
    } t_tok_ctl;

endpackage

### rtl/vdt_cell.sv
// One cell of the vertex table chain: holds one stored vertex.
// Compares the passing token, inserts a miss at the first free slot.
// Depends on vdt_pkg.
module vdt_cell
    import vdt_pkg::*;
#(
    parameter int CELL_IDX = 0,
    parameter int STORE_W  = 16,
    parameter int IDXW     = 8,
    parameter int CNTW     = 9
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [CNTW-1:0]      i_count,
    input  t_tok_ctl             i_ctl,
    input  logic [3*STORE_W-1:0] i_coord,
    input  logic [IDXW-1:0]      i_idx,
    output t_tok_ctl             o_ctl,
    output logic [3*STORE_W-1:0] o_coord,
    output logic [IDXW-1:0]      o_idx
);

    localparam logic [CNTW-1:0] MY_POS = CNTW'(CELL_IDX);
    localparam logic [IDXW-1:0] MY_IDX = IDXW'(CELL_IDX);

    logic [3*STORE_W-1:0] r_entry;
    t_tok_ctl             r_ctl;
    t_tok_ctl             n_ctl;
    logic [3*STORE_W-1:0] r_coord;
    logic [IDXW-1:0]      r_idx;
    logic [IDXW-1:0]      n_idx;
    logic                 searching;
    logic                 hit;
    logic                 ins;

    // The cell is occupied when its position lies below the fill count.
    // The first cell at or past the count takes the vertex on a miss.
    assign searching = i_ctl.valid && !i_ctl.found;
    assign hit       = searching && (MY_POS < i_count) && (r_entry == i_coord);
    assign ins       = searching && (MY_POS == i_count);

    always_comb begin
        n_ctl        = i_ctl;
        n_ctl.found  = i_ctl.found | hit | ins;
        n_ctl.is_new = i_ctl.is_new | ins;
        n_idx        = (hit || ins) ? MY_IDX : i_idx;
    end

    // Stored vertex: written once when this cell takes a new entry.
    always_ff @(posedge i_clk) begin
        if (ins) begin
            r_entry <= i_coord;
        end
    end

    // Token register toward the next cell; only the valid bit is reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else begin
            r_ctl.valid <= n_ctl.valid;
        end
        r_ctl.found    <= n_ctl.found;
        r_ctl.is_new   <= n_ctl.is_new;
        r_ctl.face_end <= n_ctl.face_end;
        r_coord        <= i_coord;
        r_idx          <= n_idx;
    end

    assign o_ctl   = r_ctl;
    assign o_coord = r_coord;
    assign o_idx   = r_idx;

endmodule

### rtl/vertex_dedup_table.sv
// Vertex deduplication table, top level: a chain of TABLE_DEPTH cells.
// The accepted vertex is registered in the entry register and then in each cell's token
// register in turn; the result strobe comes from the last cell's token register.
// A new transaction is taken only while the block is not busy, so the token walks
// through every cell of the chain before the next may enter.
// Reset (synchronous, active low) empties the table; the receiver cannot stall.
// Depends on vdt_pkg and vdt_cell.
module vertex_dedup_table
    import vdt_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
    parameter int COORD_BITS  = DEFAULT_COORD_BITS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic signed [COORD_W-1:0] i_coord_x,
    input  logic signed [COORD_W-1:0] i_coord_y,
    input  logic signed [COORD_W-1:0] i_coord_z,
    input  logic                      i_face_end,
    output logic                      o_strobe,
    output logic [INDEX_W-1:0]        o_vertex_index,
    output logic                      o_is_new,
    output logic                      o_table_full,
    output logic                      o_face_done
);

    localparam int STORE_W = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
    localparam int IDXW    = $clog2(TABLE_DEPTH);
    localparam int CNTW    = $clog2(TABLE_DEPTH + 1);

    t_tok_ctl             tok_ctl   [TABLE_DEPTH+1];
    logic [3*STORE_W-1:0] tok_coord [TABLE_DEPTH+1];
    logic [IDXW-1:0]      tok_idx   [TABLE_DEPTH+1];

    logic            r_busy;
    logic [CNTW-1:0] r_count;
    t_tok_ctl        r_tok0;
    logic [3*STORE_W-1:0] r_coord0;
    logic            accept;
    t_tok_ctl        last;

    assign accept = start && !r_busy;
    assign busy   = r_busy;
    assign last   = tok_ctl[TABLE_DEPTH];

    // Entry register: the accepted vertex becomes the token for cell zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok0.valid <= 1'b0;
        end else begin
            r_tok0.valid <= accept;
        end
        if (accept) begin
            r_tok0.found    <= 1'b0;
            r_tok0.is_new   <= 1'b0;
            r_tok0.face_end <= i_face_end;
            r_coord0        <= {i_coord_z[STORE_W-1:0], i_coord_y[STORE_W-1:0],
                                i_coord_x[STORE_W-1:0]};
        end
    end

    assign tok_ctl[0]   = r_tok0;
    assign tok_coord[0] = r_coord0;
    assign tok_idx[0]   = '0;

    // Chain of table cells, each handing the token to its neighbor.
    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        vdt_cell #(
            .CELL_IDX (g),
            .STORE_W  (STORE_W),
            .IDXW     (IDXW),
            .CNTW     (CNTW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_count (r_count),
            .i_ctl   (tok_ctl[g]),
            .i_coord (tok_coord[g]),
            .i_idx   (tok_idx[g]),
            .o_ctl   (tok_ctl[g+1]),
            .o_coord (tok_coord[g+1]),
            .o_idx   (tok_idx[g+1])
        );
    end

    // Busy from acceptance until the result leaves the chain.
    // The fill count grows when a result reports a new entry.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_count <= '0;
        end else begin
            if (accept) begin
                r_busy <= 1'b1;
            end else if (last.valid) begin
                r_busy <= 1'b0;
            end
            if (last.valid && last.is_new) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    // Result ports come straight from the last token register.
    assign o_strobe       = last.valid;
    assign o_is_new       = last.is_new;
    assign o_table_full   = !last.found;
    assign o_face_done    = last.face_end;
    assign o_vertex_index = last.found ? INDEX_W'(tok_idx[TABLE_DEPTH]) : '0;

endmodule

### rtl/vdt_checker.sv
// Port-level checker for vertex_dedup_table, with its bind statement.
// Depends on vdt_pkg.
module vdt_checker
    import vdt_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               o_strobe,
    input logic [INDEX_W-1:0] o_vertex_index,
    input logic               o_is_new,
    input logic               o_table_full
);

    // A result only appears while a transaction is in flight.
    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> busy)
        else $error("result strobe without a transaction in flight");

    // After the result the block is free again for the next transaction.
    a_free_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> (!busy && !o_strobe))
        else $error("block still busy after its result");

    // An accepted transaction holds the block busy.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    // A full-table miss stores nothing and reports index zero.
    a_full_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_table_full) |-> (!o_is_new && (o_vertex_index == '0)))
        else $error("full-table result carries a new entry or index");

endmodule

bind vertex_dedup_table vdt_checker u_vdt_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_strobe       (o_strobe),
    .o_vertex_index (o_vertex_index),
    .o_is_new       (o_is_new),
    .o_table_full   (o_table_full)
);

### sim/tb_vertex_dedup_table.sv
// Self-checking testbench for vertex_dedup_table: directed and random corners checked
// against a behavioral welding table kept in the testbench.
// Depends on vdt_pkg and the vertex_dedup_table RTL.
`timescale 1ns / 100ps

module tb_vertex_dedup_table;
    import vdt_pkg::*;

    localparam int TABLE_DEPTH  = DEFAULT_TABLE_DEPTH;
    localparam int COORD_BITS   = DEFAULT_COORD_BITS;
    localparam int RANDOM_ITEMS = 1000;
    localparam int MAX_GAP      = 400;
    localparam int DRAIN_CYCLES = TABLE_DEPTH + 40;
    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int REPORT_MAX   = 10;
    localparam logic [COORD_W-1:0] COORD_MASK = COORD_W'((64'd1 << COORD_BITS) - 1);

    // One face corner as the sender presents it.
    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic                      face_end;
        logic                      drain_first;
    } t_corner;

    // One welding result as the block returns it.
    typedef struct {
        logic [INDEX_W-1:0] index;
        logic               is_new;
        logic               table_full;
        logic               face_done;
    } t_weld;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    logic busy;
    logic signed [COORD_W-1:0] i_coord_x  = '0;
    logic signed [COORD_W-1:0] i_coord_y  = '0;
    logic signed [COORD_W-1:0] i_coord_z  = '0;
    logic                      i_face_end = 1'b0;
    logic                      o_strobe;
    logic [INDEX_W-1:0]        o_vertex_index;
    logic                      o_is_new;
    logic                      o_table_full;
    logic                      o_face_done;

    t_corner corner_queue[$];
    t_corner corner_history[$];
    t_weld   weld_expected[$];

    // Behavioral copy of the welding table.
    logic [COORD_W-1:0] welded_x [TABLE_DEPTH];
    logic [COORD_W-1:0] welded_y [TABLE_DEPTH];
    logic [COORD_W-1:0] welded_z [TABLE_DEPTH];
    int                 welded_count = 0;

    int accepted_total = 0;
    int seen_total     = 0;
    int burst_left     = 0;
    int gap_left       = 0;
    int mismatches     = 0;
    int cycle_count    = 0;

    vertex_dedup_table #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .COORD_BITS  (COORD_BITS)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_coord_x      (i_coord_x),
        .i_coord_y      (i_coord_y),
        .i_coord_z      (i_coord_z),
        .i_face_end     (i_face_end),
        .o_strobe       (o_strobe),
        .o_vertex_index (o_vertex_index),
        .o_is_new       (o_is_new),
        .o_table_full   (o_table_full),
        .o_face_done    (o_face_done)
    );

    always #5 i_clk = ~i_clk;

    // Searches the table for the lowest exact match and appends on a miss if room is left.
    function automatic t_weld weld_vertex(t_corner c);
        t_weld              r;
        logic [COORD_W-1:0] kx;
        logic [COORD_W-1:0] ky;
        logic [COORD_W-1:0] kz;
        int                 hit_at;
        kx = c.x & COORD_MASK;
        ky = c.y & COORD_MASK;
        kz = c.z & COORD_MASK;
        hit_at = -1;
        for (int i = 0; i < welded_count; i++) begin
            if (hit_at < 0 && welded_x[i] == kx && welded_y[i] == ky && welded_z[i] == kz) begin
                hit_at = i;
            end
        end
        r.face_done  = c.face_end;
        r.is_new     = 1'b0;
        r.table_full = 1'b0;
        if (hit_at >= 0) begin
            r.index = INDEX_W'(hit_at);
        end else if (welded_count < TABLE_DEPTH) begin
            welded_x[welded_count] = kx;
            welded_y[welded_count] = ky;
            welded_z[welded_count] = kz;
            r.index  = INDEX_W'(welded_count);
            r.is_new = 1'b1;
            welded_count++;
        end else begin
            r.index      = '0;
            r.table_full = 1'b1;
        end
        return r;
    endfunction

    task automatic queue_corner(input logic signed [COORD_W-1:0] x,
                                input logic signed [COORD_W-1:0] y,
                                input logic signed [COORD_W-1:0] z,
                                input logic fe, input logic drain);
        t_corner c;
        c.x           = x;
        c.y           = y;
        c.z           = z;
        c.face_end    = fe;
        c.drain_first = drain;
        corner_queue   = {corner_queue, c};
        corner_history = {corner_history, c};
    endtask

    // Stimulus, reset and end of run.
    initial begin : stimulus
        t_corner base;
        int      pick;
        int      face_left;
        logic    fe;
        logic    drain;

        // Directed corners: extremes, repeats, near misses that differ in one coordinate.
        queue_corner(16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0);
        queue_corner(16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b0);
        queue_corner(16'sd32767, 16'sd32767, 16'sd32767, 1'b0, 1'b0);
        queue_corner(-16'sd32768, -16'sd32768, -16'sd32768, 1'b0, 1'b0);
        queue_corner(-16'sd1, -16'sd1, -16'sd1, 1'b1, 1'b0);
        queue_corner(16'sd32767, -16'sd32768, 16'sd0, 1'b0, 1'b0);
        queue_corner(16'sd0, 16'sd0, 16'sd1, 1'b0, 1'b0);
        queue_corner(16'sd0, 16'sd1, 16'sd0, 1'b1, 1'b0);
        queue_corner(16'sd1, 16'sd0, 16'sd0, 1'b0, 1'b0);
        queue_corner(-16'sd32768, -16'sd32768, -16'sd32768, 1'b1, 1'b0);
        queue_corner(-16'sd1, -16'sd1, -16'sd1, 1'b0, 1'b0);
        queue_corner(16'sd32767, 16'sd32767, -16'sd32768, 1'b0, 1'b0);
        queue_corner(-16'sd1, -16'sd1, -16'sd2, 1'b1, 1'b0);
        queue_corner(16'sd32767, -16'sd32768, 16'sd0, 1'b0, 1'b0);
        queue_corner(16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b0);

        // Random faces: repeats of earlier corners, near misses and fresh vertices.
        // The fresh ones fill the table partway through, so later misses hit the full case.
        face_left = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (face_left == 0) begin
                face_left = $urandom_range(3, 4);
            end
            pick = $urandom_range(0, 99);
            base = corner_history[$urandom_range(0, corner_history.size() - 1)];
            if (pick >= 45 && pick < 65) begin
                case ($urandom_range(0, 2))
                    0: base.x = COORD_W'($urandom);
                    1: base.y = COORD_W'($urandom);
                    default: base.z = COORD_W'($urandom);
                endcase
            end else if (pick >= 65) begin
                base.x = COORD_W'($urandom);
                base.y = COORD_W'($urandom);
                base.z = COORD_W'($urandom);
            end
            fe = (face_left == 1);
            if ($urandom_range(0, 19) == 0) begin
                fe = ~fe;
            end
            face_left--;
            drain = (n == 0) || ($urandom_range(0, 39) == 0);
            queue_corner(base.x, base.y, base.z, fe, drain);
        end

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (corner_queue.size() != 0 || weld_expected.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && weld_expected.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Driver: bursts of corners separated by random gaps, with an occasional
    // hold until every outstanding result has come back.
    always @(negedge i_clk) begin : driver
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (accepted_total != seen_total) begin
                seen_total = accepted_total;
                if (burst_left > 0) begin
                    burst_left--;
                end
            end
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 6);
                gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, MAX_GAP);
            end
            if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end else if (corner_queue.size() != 0 &&
                         !(corner_queue[0].drain_first && weld_expected.size() != 0)) begin
                i_coord_x  <= corner_queue[0].x;
                i_coord_y  <= corner_queue[0].y;
                i_coord_z  <= corner_queue[0].z;
                i_face_end <= corner_queue[0].face_end;
                start      <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: checks each strobed result, then records an accepted transaction.
    always @(posedge i_clk) begin : monitor
        t_weld   got;
        t_weld   want;
        t_corner c;
        if (i_rst_n) begin
            if (o_strobe === 1'b1) begin
                got.index      = o_vertex_index;
                got.is_new     = o_is_new;
                got.table_full = o_table_full;
                got.face_done  = o_face_done;
                if (weld_expected.size() == 0) begin
                    if (mismatches < REPORT_MAX) begin
                        $display("Unexpected result: index %0d new %b full %b done %b",
                                 got.index, got.is_new, got.table_full, got.face_done);
                    end
                    mismatches++;
                end else begin
                    want = weld_expected.pop_front();
                    // The index carries no meaning when a miss could not be stored.
                    if ((!want.table_full && got.index !== want.index) ||
                        got.is_new !== want.is_new || got.table_full !== want.table_full ||
                        got.face_done !== want.face_done) begin
                        if (mismatches < REPORT_MAX) begin
                            $display("Mismatch (exp/got): index %0d/%0d new %b/%b full %b/%b done %b/%b",
                                     want.index, got.index, want.is_new, got.is_new,
                                     want.table_full, got.table_full,
                                     want.face_done, got.face_done);
                        end
                        mismatches++;
                    end
                end
            end
            if (start === 1'b1 && busy === 1'b0 && corner_queue.size() != 0) begin
                c = corner_queue.pop_front();
                want = weld_vertex(c);
                weld_expected = {weld_expected, want};
                accepted_total++;
            end
        end
    end

    // Run limit.
    always @(posedge i_clk) begin : watchdog
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

endmodule
